// ----- rtl/core/per_key_occurrence_history_assert.svh -----
// ----------------------------------------------------------------------------
// per_key_occurrence_history_assert.svh
// Assertion macros shared by the per-key occurrence history block.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_OCCURRENCE_HISTORY_ASSERT_SVH
`define PER_KEY_OCCURRENCE_HISTORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKOH_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKOH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pkoh_pkg.sv -----
// ----------------------------------------------------------------------------
// pkoh_pkg
// Types, constants and helper functions of the per-key occurrence history.
// ----------------------------------------------------------------------------
`default_nettype none

package pkoh_pkg;

   // Sizing of the block.
   localparam int NUM_KEYS     = 256;
   localparam int MAX_LAGS     = 8;
   localparam int MAX_OUT_LAGS = 6;
   localparam int POS_BITS     = 32;

   // Fixed field widths.
   localparam int FIELD_KEY_BITS = 8;
   localparam int LAG_BITS       = 3;
   localparam int OUT_POS_BITS   = 32;
   localparam int LAG_REGS       = 6;
   localparam int LAG_IDX_BITS   = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 3;

   // Derived widths.
   localparam int KEY_BITS  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SLOT_BITS = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAG_COUNT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAG_FIRST = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAG_LAST  = 3'd6;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_PROCESS = 1'b1
   } opcode_type;

   typedef logic [LAG_BITS-1:0] lag_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [FIELD_KEY_BITS-1:0] key;
      logic [FIELD_KEY_BITS-1:0] class_key;
   } req_type;

   typedef struct packed {
      lag_type                 lag_slot;
      logic                    found;
      logic [OUT_POS_BITS-1:0] position;
      logic                    last;
   } rsp_type;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic [LAG_BITS-1:0]        lag_count;
      lag_type [LAG_REGS-1:0]     lag;
   } cfg_type;

   // One history slot and one row of slots, newest in slot 0.
   typedef struct packed {
      logic                valid;
      logic [POS_BITS-1:0] pos;
   } hist_slot_type;

   typedef hist_slot_type [MAX_LAGS-1:0] hist_row_type;

   localparam int HIST_ROW_BITS = $bits(hist_row_type);

   // Reduction of an 8-bit key to a table row, worked out at elaboration.
   typedef logic [KEY_BITS-1:0] key_mod_table_type [256];

   function automatic key_mod_table_type build_key_mod_table();
      key_mod_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = KEY_BITS'(i % NUM_KEYS);
      end
      return t;
   endfunction

   localparam key_mod_table_type KEY_MOD_TABLE = build_key_mod_table();

   function automatic logic [KEY_BITS-1:0] key_mod(input logic [FIELD_KEY_BITS-1:0] k);
      return KEY_MOD_TABLE[k];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/per_key_occurrence_history.sv -----
// ----------------------------------------------------------------------------
// per_key_occurrence_history
// Keeps the recent stream positions of every key and reports, for each
// configured lag, the position held in the history of the key's class.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_data (opcode, key, class_key)
//   rsp      out        rsp_valid/rsp_ready  rsp_data (lag_slot, found, ...)
//   csr      in         csr_we               csr_index, csr_wdata
//
// A load transaction writes the class map when it is accepted. A process
// transaction steps through map read, class row read, key row read and
// write back, then gives its results, one a cycle, through the output
// register while that register is free. The single read port of the
// history memory sets this order. After reset a clearing pass writes every
// history row before the first transaction is accepted.
// A stalled result holds the engine; the next transaction is taken while
// the final result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_key_occurrence_history_assert.svh"

module per_key_occurrence_history (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire pkoh_pkg::req_type                  req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      pkoh_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [pkoh_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [pkoh_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import pkoh_pkg::*;

   cfg_type cfg;

   // Conditions watched by the assertions below.
   logic process_accept;
   logic mid_burst;
   logic missing_slot;
   logic position_zero;

   // Configuration registers.
   pkoh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Memory sequencer and result stream.
   pkoh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cfg       (cfg)
   );

   assign process_accept = req_valid && req_ready && (req_data.opcode == OP_PROCESS);
   assign mid_burst      = rsp_valid && !rsp_data.last;
   assign missing_slot   = rsp_valid && !rsp_data.found;
   assign position_zero  = (rsp_data.position == '0);

   // The clearing pass runs straight after reset.
   `PKOH_ASSERT_SAME(a_clear_busy, clock, reset, $past(reset), !req_ready, "ready while clearing")

   // A process transaction keeps the block busy in the next cycle.
   `PKOH_ASSERT_NEXT(a_busy_next, clock, reset, process_accept, !req_ready, "ready after process")

   // No transaction is taken in the middle of a burst of results.
   `PKOH_ASSERT_SAME(a_mid_burst_busy, clock, reset, mid_burst, !req_ready, "ready mid burst")

   // A slot that holds nothing reports position zero.
   `PKOH_ASSERT_SAME(a_zero_missing, clock, reset, missing_slot, position_zero, "position set")

endmodule

`default_nettype wire

// ----- rtl/core/pkoh_ram.sv -----
// ----------------------------------------------------------------------------
// pkoh_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pkoh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pkoh_csr.sv -----
// ----------------------------------------------------------------------------
// pkoh_csr
// Configuration registers: the lag count and the six lag slot selectors.
// ----------------------------------------------------------------------------
`default_nettype none

module pkoh_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [pkoh_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [pkoh_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output      pkoh_pkg::cfg_type                    cfg
);

   import pkoh_pkg::*;

   logic [LAG_BITS-1:0]    lag_count_ff;
   logic [LAG_BITS-1:0]    lag_count_in;
   lag_type [LAG_REGS-1:0] lag_ff;
   lag_type [LAG_REGS-1:0] lag_in;

   // Decode a write to one register; unknown indexes are ignored.
   always_comb begin
      lag_count_in = lag_count_ff;
      lag_in       = lag_ff;
      if (csr_we) begin
         if (csr_index == CSR_LAG_COUNT) begin
            lag_count_in = csr_wdata;
         end else if (csr_index inside {[CSR_LAG_FIRST:CSR_LAG_LAST]}) begin
            lag_in[LAG_IDX_BITS'(csr_index - CSR_LAG_FIRST)] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_count_ff <= LAG_BITS'(1);
         for (int i = 0; i < LAG_REGS; i++) begin
            lag_ff[i] <= LAG_BITS'(i);
         end
      end else begin
         lag_count_ff <= lag_count_in;
         lag_ff       <= lag_in;
      end
   end

   assign cfg.lag_count = lag_count_ff;
   assign cfg.lag       = lag_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pkoh_engine.sv -----
// ----------------------------------------------------------------------------
// pkoh_engine
// Sequencer around the class map and history memories: maps the key, reads
// the class key's row, shifts the key's own row and streams out the results.
// ----------------------------------------------------------------------------
`default_nettype none

module pkoh_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire pkoh_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      pkoh_pkg::rsp_type rsp_data,
   input  wire pkoh_pkg::cfg_type cfg
);

   import pkoh_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_MAP   = 6'b000100,
      S_CROW  = 6'b001000,
      S_KROW  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [KEY_BITS-1:0]      clear_addr_ff, clear_addr_in;
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [LAG_IDX_BITS-1:0]  lag_idx_ff, lag_idx_in;
   hist_row_type             class_row_ff, class_row_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     out_free;
   logic                     emit;

   // Memory port signals.
   logic                      map_wr_en;
   logic [FIELD_KEY_BITS-1:0] map_rd_data;
   logic                      hist_wr_en;
   logic [KEY_BITS-1:0]       hist_wr_addr;
   hist_row_type              hist_wr_data;
   logic [KEY_BITS-1:0]       hist_rd_addr;
   hist_row_type              hist_rd_data;

   // Result formation.
   logic [LAG_IDX_BITS-1:0]  lag_total;
   lag_type                  slot;
   logic                     slot_in_range;
   hist_slot_type            slot_entry;
   logic                     slot_found;
   logic                     is_last;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == S_EMIT) && out_free;

   // Key-to-class map: written on a load transaction, read on every accept.
   pkoh_ram #(
      .WIDTH (FIELD_KEY_BITS),
      .DEPTH (NUM_KEYS)
   ) u_class_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (key_mod(req_data.key)),
      .wr_data (req_data.class_key),
      .rd_addr (key_mod(req_data.key)),
      .rd_data (map_rd_data)
   );

   assign map_wr_en = accept && (req_data.opcode == OP_LOAD);

   // History rows, one per key.
   pkoh_ram #(
      .WIDTH (HIST_ROW_BITS),
      .DEPTH (NUM_KEYS)
   ) u_history (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // Read the class key's row first, then the key's own row.
   assign hist_rd_addr = (state_ff == S_MAP) ? key_mod(map_rd_data) : key_ff;

   // Write either a cleared row or the shifted row with the new position.
   always_comb begin
      hist_wr_en   = 1'b0;
      hist_wr_addr = key_ff;
      hist_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         hist_wr_en   = 1'b1;
         hist_wr_addr = clear_addr_ff;
      end else if (state_ff == S_KROW) begin
         hist_wr_en = 1'b1;
         for (int s = MAX_LAGS - 1; s > 0; s--) begin
            hist_wr_data[s] = hist_rd_data[s-1];
         end
         hist_wr_data[0].valid = 1'b1;
         hist_wr_data[0].pos   = pos_ff;
      end
   end

   // Number of results for this transaction, held within one and the maximum.
   always_comb begin
      if (cfg.lag_count == '0) begin
         lag_total = LAG_IDX_BITS'(1);
      end else if (int'(cfg.lag_count) > MAX_OUT_LAGS) begin
         lag_total = LAG_IDX_BITS'(MAX_OUT_LAGS);
      end else begin
         lag_total = cfg.lag_count;
      end
   end

   // Look up the selected slot of the captured class row.
   assign slot          = cfg.lag[lag_idx_ff];
   assign slot_in_range = (int'(slot) < MAX_LAGS);
   assign slot_entry    = class_row_ff[SLOT_BITS'(slot)];
   assign slot_found    = slot_in_range && slot_entry.valid;
   assign is_last       = (lag_idx_ff == lag_total - LAG_IDX_BITS'(1));

   // Sequencer and datapath registers.
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      clear_addr_in = clear_addr_ff;
      pos_in        = pos_ff;
      lag_idx_in    = lag_idx_ff;
      class_row_in  = class_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clear_addr_in = clear_addr_ff + KEY_BITS'(1);
            if (clear_addr_ff == KEY_BITS'(NUM_KEYS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && (req_data.opcode == OP_PROCESS)) begin
               key_in   = key_mod(req_data.key);
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in = S_CROW;
         end
         S_CROW: begin
            class_row_in = hist_rd_data;
            state_in     = S_KROW;
         end
         S_KROW: begin
            pos_in     = pos_ff + POS_BITS'(1);
            lag_idx_in = '0;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (emit) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.lag_slot = slot;
               rsp_data_in.found    = slot_found;
               rsp_data_in.position = slot_found ? OUT_POS_BITS'(slot_entry.pos) : '0;
               rsp_data_in.last     = is_last;
               lag_idx_in           = lag_idx_ff + LAG_IDX_BITS'(1);
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         pos_ff        <= '0;
         lag_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         pos_ff        <= pos_in;
         lag_idx_ff    <= lag_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      class_row_ff <= class_row_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- verif/occurrence_history_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occurrence_history_checker
// Watches the request, result and register ports of the per-key occurrence
// history block. It keeps its own copy of the class map, the history rows,
// the stream position and the lag registers. It predicts the results of
// every accepted process transaction and compares each result transaction,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module occurrence_history_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  pkoh_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  pkoh_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [pkoh_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pkoh_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  results_checked
);

   import pkoh_pkg::*;

   hist_slot_type             history [NUM_KEYS][MAX_LAGS];
   logic [FIELD_KEY_BITS-1:0] class_of [NUM_KEYS];
   logic [POS_BITS-1:0]       stream_position;
   logic [LAG_BITS-1:0]       lag_count_reg;
   lag_type                   lag_select [LAG_REGS];
   rsp_type                   expected_lags [$];
   rsp_type                   oldest;
   int                        mismatches;
   int                        checked;

   // Works out the results of one request transaction and updates the
   // mirrored map and history in the same way as the block.
   task automatic record_occurrence(input req_type item);
      int      row;
      int      class_row;
      int      n;
      rsp_type lag_result;
      if (item.opcode == OP_LOAD) begin
         class_of[int'(item.key) % NUM_KEYS] = item.class_key;
      end else begin
         row       = int'(item.key) % NUM_KEYS;
         class_row = int'(class_of[row]) % NUM_KEYS;
         n         = int'(lag_count_reg);
         if (n == 0) begin
            n = 1;
         end
         if (n > MAX_OUT_LAGS) begin
            n = MAX_OUT_LAGS;
         end
         // The class row is read as it stood before this occurrence.
         for (int r = 0; r < n; r++) begin
            lag_result.lag_slot = lag_select[r];
            lag_result.found    = 1'b0;
            lag_result.position = '0;
            if (int'(lag_select[r]) < MAX_LAGS && history[class_row][lag_select[r]].valid) begin
               lag_result.found    = 1'b1;
               lag_result.position = OUT_POS_BITS'(history[class_row][lag_select[r]].pos);
            end
            lag_result.last = (r == n - 1);
            expected_lags.push_back(lag_result);
         end
         // Age the key's own row by one slot and put the current position in front.
         for (int s = MAX_LAGS - 1; s > 0; s--) begin
            history[row][s] = history[row][s - 1];
         end
         history[row][0].valid = 1'b1;
         history[row][0].pos   = stream_position;
         stream_position       = stream_position + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         // Mirror the reset state: empty histories and the default lags.
         for (int k = 0; k < NUM_KEYS; k++) begin
            class_of[k] = '0;
            for (int s = 0; s < MAX_LAGS; s++) begin
               history[k][s] = '0;
            end
         end
         stream_position = '0;
         lag_count_reg   = LAG_BITS'(1);
         for (int i = 0; i < LAG_REGS; i++) begin
            lag_select[i] = lag_type'(i);
         end
         expected_lags.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         // A result transaction is held against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_lags.size() == 0) begin
               $error("result transaction with no prediction waiting: %h", rsp_data);
               mismatches++;
            end else begin
               oldest = expected_lags.pop_front();
               checked++;
               if (rsp_data.lag_slot !== oldest.lag_slot) begin
                  $error("lag_slot: expected %0d, actual %0d", oldest.lag_slot,
                         rsp_data.lag_slot);
                  mismatches++;
               end
               if (rsp_data.found !== oldest.found) begin
                  $error("found: expected %0d, actual %0d", oldest.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.position !== oldest.position) begin
                  $error("position: expected %0d, actual %0d", oldest.position,
                         rsp_data.position);
                  mismatches++;
               end
               if (rsp_data.last !== oldest.last) begin
                  $error("last: expected %0d, actual %0d", oldest.last, rsp_data.last);
                  mismatches++;
               end
            end
         end

         // Register writes; an index outside the list is ignored.
         if (csr_we) begin
            if (csr_index == CSR_LAG_COUNT) begin
               lag_count_reg = csr_wdata;
            end else if (csr_index >= CSR_LAG_FIRST && csr_index <= CSR_LAG_LAST) begin
               lag_select[csr_index - CSR_LAG_FIRST] = csr_wdata;
            end
         end

         // Predict for each accepted request transaction.
         if (req_valid && req_ready) begin
            record_occurrence(req_data);
         end
      end
      fail_count      <= mismatches;
      pending_count   <= expected_lags.size();
      results_checked <= checked;
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the per-key occurrence history block with map loads and key
// occurrences under several lag settings, with random idling on both
// channels, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module testbench;

   import pkoh_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int IDLE_PERCENT    = 28;
   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_AT_RESULT  = 30;
   localparam int HOLD_CYCLES     = 150;
   localparam int STEADY_FIRST    = 150;
   localparam int STEADY_LAST     = 260;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 16;
   localparam int POOL_SIZE       = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = CSR_LAG_LAST + 1'b1;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we      = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;
   int                        fail_count;
   int                        pending_count;
   int                        results_checked;
   int                        items_sent    = 0;
   int                        settings_used = 0;
   int                        results_taken = 0;
   int                        hold_left     = 0;
   logic                      steady_send   = 1'b0;
   logic                      map_loaded [NUM_KEYS];
   logic [FIELD_KEY_BITS-1:0] key_pool [POOL_SIZE];

   always #HALF_PERIOD clock = ~clock;

   per_key_occurrence_history u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   occurrence_history_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   // Result side: random idling, one long hold-off early in the run so that
   // the block fills up, and a stretch of steady acceptance later on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         hold_left     <= 0;
         results_taken <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_taken <= results_taken + 1;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (rsp_valid && rsp_ready && results_taken == HOLD_AT_RESULT) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
         end else if (results_taken >= STEADY_FIRST && results_taken < STEADY_LAST) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Ends the run when no transaction has been accepted for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type make_req(input opcode_type op,
                                        input logic [FIELD_KEY_BITS-1:0] key,
                                        input logic [FIELD_KEY_BITS-1:0] class_key);
      req_type item;
      item.opcode    = op;
      item.key       = key;
      item.class_key = class_key;
      return item;
   endfunction

   // Offers one request transaction and returns at the edge that accepts it.
   task automatic send_item(input req_type item);
      while (!steady_send && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (item.opcode == OP_LOAD) begin
         map_loaded[item.key] = 1'b1;
      end
      items_sent++;
   endtask

   // Mostly occurrences of a small set of keys that map onto one another, so
   // that histories fill; the rest are loads and keys from the whole range.
   task automatic send_random_item();
      req_type item;
      int      k;
      item.class_key = FIELD_KEY_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 20) begin
         item.opcode = OP_LOAD;
         if ($urandom_range(0, 3) == 0) begin
            item.key = FIELD_KEY_BITS'($urandom_range(0, 255));
         end else begin
            item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         if ($urandom_range(0, 3) != 0) begin
            item.class_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
      end else begin
         item.opcode = OP_PROCESS;
         // Only keys whose map entry has been loaded may occur.
         if ($urandom_range(0, 4) == 0) begin
            do begin
               k = $urandom_range(0, NUM_KEYS - 1);
            end while (!map_loaded[k]);
         end else begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         item.key = FIELD_KEY_BITS'(k);
      end
      send_item(item);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0]  index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes every register, then the unused index, which must change nothing.
   task automatic write_settings(input logic [CSR_DATA_BITS-1:0] count,
                                 input lag_type [LAG_REGS-1:0]   lags);
      write_csr(CSR_LAG_COUNT, count);
      for (int i = 0; i < LAG_REGS; i++) begin
         write_csr(CSR_IDX_BITS'(CSR_LAG_FIRST + i), lags[i]);
      end
      write_csr(CSR_SPARE, CSR_DATA_BITS'($urandom_range(0, 7)));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Waits until every predicted result has arrived and the block has settled.
   // The first edge lets the checker's count take in the last accepted request.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      lag_type [LAG_REGS-1:0]   lags;
      logic [CSR_DATA_BITS-1:0] count;
      for (int k = 0; k < NUM_KEYS; k++) begin
         map_loaded[k] = 1'b0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = FIELD_KEY_BITS'($urandom_range(1, 254));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Six results per key; slots 0 to 5 report 0, 7, 1, 6, 2 and 5.
      write_settings(3'd6, {3'd5, 3'd2, 3'd6, 3'd1, 3'd7, 3'd0});

      // Directed part: key extremes, a class row still empty, a row filled in
      // all eight slots, a key mapped onto itself and an overwritten map entry.
      send_item(make_req(OP_LOAD, 8'h00, 8'hFF));
      send_item(make_req(OP_LOAD, 8'hFF, 8'h00));
      send_item(make_req(OP_LOAD, 8'hAA, 8'h55));
      send_item(make_req(OP_LOAD, 8'h55, 8'h55));
      send_item(make_req(OP_PROCESS, 8'h00, 8'h00));
      repeat (9) send_item(make_req(OP_PROCESS, 8'hFF, 8'hFF));
      send_item(make_req(OP_PROCESS, 8'h00, 8'hAA));
      send_item(make_req(OP_PROCESS, 8'h55, 8'h00));
      send_item(make_req(OP_PROCESS, 8'h55, 8'hFF));
      send_item(make_req(OP_LOAD, 8'h55, 8'hAA));
      send_item(make_req(OP_PROCESS, 8'hAA, 8'h0F));
      send_item(make_req(OP_PROCESS, 8'h55, 8'hF0));
      req_valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < LAG_REGS; i++) begin
            lags[i] = lag_type'($urandom_range(0, 7));
         end
         count = CSR_DATA_BITS'($urandom_range(1, MAX_OUT_LAGS));
         case (p)
            0: begin
               count   = 3'd1;
               lags[0] = 3'd7;
            end
            1: begin
               // A count above the limit saturates to six results.
               count = 3'd7;
               lags  = {3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
            end
            2: begin
               // A count of zero gives one result.
               count   = 3'd0;
               lags[0] = 3'd0;
            end
            4: begin
               count = 3'd6;
            end
            default: begin
            end
         endcase
         write_settings(count, lags);
         steady_send = (p == 2);

         // Map the key set onto itself before random occurrences begin.
         if (p == 0) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
               send_item(make_req(OP_LOAD, key_pool[i], key_pool[(i + 1) % POOL_SIZE]));
            end
         end
         repeat (ITEMS_PER_PHASE) send_random_item();
         req_valid <= 1'b0;
         wait_drained();
      end

      $display("Sent %0d request transactions under %0d lag settings, %0d results checked.",
               items_sent, settings_used, results_checked);
      $display("Covered key extremes, full histories, saturated and zero lag counts.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pkoh_pkg.sv
rtl/core/pkoh_ram.sv
rtl/core/pkoh_csr.sv
rtl/core/pkoh_engine.sv
rtl/core/per_key_occurrence_history.sv
verif/occurrence_history_checker.sv
verif/testbench.sv
